// File: src/assert_macros.svh
// Assertion macros used by the checker file of the hash table block.
// Depends on nothing; included by the checker module only.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed");

// Next-cycle implication that is also checked across reset.
`define ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: src/lpht_pkg.sv
// Package of the linear probe hash table: sizes, status codes, helper function
// and the command and status structs between controller and datapath.
// Depends on nothing.
package lpht_pkg;

  // The table size must be a power of two; the home slot is the low key bits.
  localparam int TABLE_SIZE = 256;
  localparam int IDX_W      = $clog2(TABLE_SIZE);
  localparam int CNT_W      = IDX_W + 1;
  localparam int KEY_W      = 32;
  localparam int VAL_W      = 32;
  localparam int SLOT_W     = 8;
  localparam int STAT_W     = 3;

  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(TABLE_SIZE - 1);

  typedef enum logic [0:0] {
    OP_INSERT = 1'b0,
    OP_LOOKUP = 1'b1
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_PRESENT   = 3'd1,
    ST_COLLISION = 3'd2,
    ST_FULL      = 3'd3,
    ST_FOUND     = 3'd4,
    ST_NOT_FOUND = 3'd5,
    ST_ZERO      = 3'd6
  } status_t;

  typedef struct packed {
    logic load;
    logic step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic done;
    logic out_free;
  } sts_t;

  function automatic logic [SLOT_W-1:0] to_slot(input logic [IDX_W-1:0] a);
    logic [IDX_W+SLOT_W-1:0] w;
    w = {{SLOT_W{1'b0}}, a};
    return w[SLOT_W-1:0];
  endfunction

endpackage

// File: src/linear_probe_hash_table.sv
// Linear probe hash table: top level joining controller and datapath.
// Items are taken one at a time: a new item is accepted only once the last has finished.
// The probe reads one slot per cycle from the key and value memories, and a
// result held in the output register stalls the probe. Zero-value and full
// inserts finish at the first slot probed, without a key match.
// Reset clears the slot valid bits and entry count at once; no clearing pass.
module linear_probe_hash_table (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // key_hash [31:0], entry_value [63:32]
  input  logic [0:0]  in_tuser,   // opcode [0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // found_value [31:0], slot_index [39:32]
  output logic [2:0]  out_tuser   // status [2:0]
);
  import lpht_pkg::*;

  cmd_t cmd;
  sts_t sts;

  lpht_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  lpht_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_opcode       (in_tuser[0]),
    .in_key_hash     (in_tdata[31:0]),
    .in_entry_value  (in_tdata[63:32]),
    .cmd             (cmd),
    .sts             (sts),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_status      (out_tuser),
    .out_found_value (out_tdata[31:0]),
    .out_slot_index  (out_tdata[39:32])
  );

endmodule

// File: src/lpht_ctrl.sv
// Controller of the linear probe hash table: accepts items and sequences the
// probe. Depends on lpht_pkg; drives the datapath through cmd_t.
module lpht_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  lpht_pkg::sts_t sts,
  output lpht_pkg::cmd_t cmd
);
  import lpht_pkg::*;

  typedef enum logic [0:0] {
    S_IDLE  = 1'b0,
    S_PROBE = 1'b1
  } state_t;

  state_t state_r;
  state_t state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_PROBE;
        end
      end
      S_PROBE: begin
        if (!sts.done) begin
          cmd.step = 1'b1;
        end else if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: src/lpht_dp.sv
// Datapath of the linear probe hash table: key and value memories, slot valid
// bits, entry count, probe address and output register. Depends on lpht_pkg.
module lpht_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_opcode,
  input  logic [lpht_pkg::KEY_W-1:0]    in_key_hash,
  input  logic [lpht_pkg::VAL_W-1:0]    in_entry_value,
  input  lpht_pkg::cmd_t                cmd,
  output lpht_pkg::sts_t                sts,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [lpht_pkg::STAT_W-1:0]   out_status,
  output logic [lpht_pkg::VAL_W-1:0]    out_found_value,
  output logic [lpht_pkg::SLOT_W-1:0]   out_slot_index
);
  import lpht_pkg::*;

  logic [KEY_W-1:0] key_mem [TABLE_SIZE];
  logic [VAL_W-1:0] val_mem [TABLE_SIZE];
  logic [TABLE_SIZE-1:0] used_r;
  logic [CNT_W-1:0] count_r;

  logic             op_r;
  logic [KEY_W-1:0] key_r;
  logic [VAL_W-1:0] val_r;
  logic             zero_r;
  logic             full_r;
  logic [IDX_W-1:0] addr_r;
  logic [IDX_W-1:0] addr_nxt;
  logic [KEY_W-1:0] key_rd_r;
  logic [VAL_W-1:0] val_rd_r;

  logic             out_valid_r;
  status_t          status_r;
  logic [VAL_W-1:0] fval_r;
  logic [SLOT_W-1:0] slot_r;

  logic    used_hit;
  logic    special;
  logic    do_write;
  status_t status_nxt;
  logic [VAL_W-1:0] fval_nxt;
  logic [SLOT_W-1:0] slot_nxt;

  always_comb begin
    priority if (cmd.load) begin
      addr_nxt = in_key_hash[IDX_W-1:0];
    end else if (cmd.step) begin
      addr_nxt = addr_r + IDX_W'(1);
    end else begin
      addr_nxt = addr_r;
    end
  end

  assign used_hit = used_r[addr_r];
  assign special  = (op_r == OP_INSERT) && (zero_r || full_r);
  assign sts.done = special || !used_hit || (key_rd_r == key_r);
  assign sts.out_free = !out_valid_r || out_tready;
  assign do_write = cmd.finish && (op_r == OP_INSERT) && !special && !used_hit;

  always_comb begin
    fval_nxt = '0;
    slot_nxt = to_slot(addr_r);
    priority if (op_r == OP_INSERT && zero_r) begin
      status_nxt = ST_ZERO;
      slot_nxt   = '0;
    end else if (op_r == OP_INSERT && full_r) begin
      status_nxt = ST_FULL;
      slot_nxt   = '0;
    end else if (op_r == OP_INSERT) begin
      if (used_hit) begin
        fval_nxt   = val_rd_r;
        status_nxt = (val_rd_r == val_r) ? ST_PRESENT : ST_COLLISION;
      end else begin
        status_nxt = ST_INSERTED;
      end
    end else begin
      if (used_hit) begin
        fval_nxt   = val_rd_r;
        status_nxt = ST_FOUND;
      end else begin
        status_nxt = ST_NOT_FOUND;
      end
    end
  end

  always_ff @(posedge clk) begin
    key_rd_r <= key_mem[addr_nxt];
    val_rd_r <= val_mem[addr_nxt];
    if (do_write) begin
      key_mem[addr_r] <= key_r;
      val_mem[addr_r] <= val_r;
    end
  end

  always_ff @(posedge clk) begin
    addr_r <= addr_nxt;
    if (cmd.load) begin
      op_r   <= in_opcode;
      key_r  <= in_key_hash;
      val_r  <= in_entry_value;
      zero_r <= (in_entry_value == '0);
      full_r <= (count_r >= FULL_COUNT);
    end
    if (cmd.finish) begin
      status_r <= status_nxt;
      fval_r   <= fval_nxt;
      slot_r   <= slot_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (do_write) begin
        used_r[addr_r] <= 1'b1;
        count_r        <= count_r + CNT_W'(1);
      end
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid      = out_valid_r;
  assign out_status      = status_r;
  assign out_found_value = fval_r;
  assign out_slot_index  = slot_r;

endmodule

// File: src/lpht_chk.sv
// Port-level checker of the linear probe hash table, bound to the top level.
// Depends on lpht_pkg and assert_macros.svh.
`include "assert_macros.svh"

module lpht_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic [2:0]  out_tuser
);
  import lpht_pkg::*;

  logic refused;

  assign refused = out_tvalid && (out_tuser == ST_ZERO || out_tuser == ST_FULL);

  `ASSERT_NEXT_ALWAYS(a_reset_idle, clk, !rst_n, !out_tvalid && in_tready)
  `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_tvalid && in_tready, !in_tready)
  `ASSERT_IMPL(a_status_legal, clk, rst_n, out_tvalid, out_tuser != 3'd7)
  `ASSERT_IMPL(a_refused_zero, clk, rst_n, refused, out_tdata == '0)
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser))

endmodule

bind linear_probe_hash_table lpht_chk u_lpht_chk (.*);

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench of linear_probe_hash_table: directed and random insert and
// lookup items against an in-bench copy of the table. Depends on lpht_pkg and the RTL.
module tb_top;
  import lpht_pkg::*;

  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    status_t          status;
    logic [VAL_W-1:0] value;
    logic [7:0]       slot;
  } reply_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;   // key_hash [31:0], entry_value [63:32]
  logic [0:0]  in_tuser;   // opcode [0]
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;  // found_value [31:0], slot_index [39:32]
  logic [2:0]  out_tuser;  // status [2:0]

  logic [KEY_W-1:0] tbl_key [TABLE_SIZE];
  logic [VAL_W-1:0] tbl_val [TABLE_SIZE];
  bit               tbl_used [TABLE_SIZE];
  int               tbl_count;

  logic [KEY_W-1:0] stored_keys [$];
  logic [VAL_W-1:0] stored_vals [$];
  reply_t           pending_replies [$];

  int  err_count;
  int  cycle_count;
  int  items_sent;
  int  replies_seen;
  int  status_seen [7];
  int  burst_left;
  bit  steady_send;
  bit  hold_req;
  int  hold_left;
  int  rx_mode;
  int  rx_left;
  int  rx_phase;

  linear_probe_hash_table dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic reply_t hash_table_apply(op_t op, logic [KEY_W-1:0] key,
                                              logic [VAL_W-1:0] val);
    reply_t      r;
    int unsigned idx;
    bit          hit;
    r.status = ST_NOT_FOUND;
    r.value  = '0;
    r.slot   = '0;
    if (op == OP_INSERT && val == '0) begin
      r.status = ST_ZERO;
      return r;
    end
    if (op == OP_INSERT && tbl_count >= TABLE_SIZE - 1) begin
      r.status = ST_FULL;
      return r;
    end
    idx = key % 32'(TABLE_SIZE);
    hit = 1'b0;
    for (int n = 0; n < TABLE_SIZE && !hit; n++) begin
      if (!tbl_used[idx] || tbl_key[idx] == key) hit = 1'b1;
      else idx = (idx + 1) % TABLE_SIZE;
    end
    if (!hit) begin
      r.status = (op == OP_INSERT) ? ST_FULL : ST_NOT_FOUND;
      return r;
    end
    r.slot = idx[7:0];
    if (op == OP_LOOKUP) begin
      if (tbl_used[idx]) begin
        r.status = ST_FOUND;
        r.value  = tbl_val[idx];
      end
    end else if (tbl_used[idx]) begin
      r.value  = tbl_val[idx];
      r.status = (tbl_val[idx] == val) ? ST_PRESENT : ST_COLLISION;
    end else begin
      tbl_used[idx] = 1'b1;
      tbl_key[idx]  = key;
      tbl_val[idx]  = val;
      tbl_count++;
      r.status = ST_INSERTED;
    end
    return r;
  endfunction

  // Starts and ends at a falling edge. Leaves in_tvalid high unless a gap follows.
  task automatic send_item(op_t op, logic [KEY_W-1:0] key, logic [VAL_W-1:0] val);
    reply_t r;
    int     gap;
    in_tdata  <= {val, key};
    in_tuser  <= op;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    r = hash_table_apply(op, key, val);
    pending_replies.push_back(r);
    if (r.status == ST_INSERTED) begin
      stored_keys.push_back(key);
      stored_vals.push_back(val);
    end
    items_sent++;
    @(negedge clk);
    if (!steady_send) begin
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        gap = $urandom_range(1, 8);
        burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
                                                  : $urandom_range(0, 12);
        in_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [VAL_W-1:0] nonzero_value();
    logic [VAL_W-1:0] v;
    v = $urandom;
    if (v == '0) v = 1;
    return v;
  endfunction

  // Half of the keys land in two crowded home regions, one of them wrapping past the top slot.
  function automatic logic [KEY_W-1:0] random_key();
    logic [KEY_W-1:0] k;
    k = $urandom;
    case ($urandom_range(0, 3))
      0: k[7:0] = 8'hFC + 8'($urandom_range(0, 5));
      1: k[7:0] = 8'h40 + 8'($urandom_range(0, 7));
      default: ;
    endcase
    return k;
  endfunction

  always @(posedge clk) begin
    reply_t exp;
    reply_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.status = status_t'(out_tuser);
      got.value  = out_tdata[31:0];
      got.slot   = out_tdata[39:32];
      replies_seen++;
      if (out_tuser < 3'd7) status_seen[out_tuser]++;
      if (pending_replies.size() == 0) begin
        err_count++;
        if (err_count <= 50)
          $display("%0t: result with nothing expected: status %0d value %h slot %0d",
                   $time, out_tuser, got.value, got.slot);
      end else begin
        exp = pending_replies.pop_front();
        if (got.status !== exp.status || got.value !== exp.value || got.slot !== exp.slot)
        begin
          err_count++;
          if (err_count <= 50)
            $display("%0t: expected status %0d value %h slot %0d, actual status %0d value %h slot %0d",
                     $time, exp.status, exp.value, exp.slot, out_tuser, got.value, got.slot);
        end
      end
    end
  end

  always @(negedge clk) begin
    if (hold_req && hold_left == 0) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_left = $urandom_range(20, 80);
      end
      rx_left--;
      rx_phase++;
      case (rx_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= (rx_phase % 4 != 3);
        2: out_tready <= 1'($urandom_range(0, 1));
        default: out_tready <= (rx_phase % 8 < 2);
      endcase
    end
  end

  task automatic test_directed();
    send_item(OP_INSERT, 32'h0000_0000, 32'h0000_0000);
    send_item(OP_LOOKUP, 32'h0000_0000, 32'h0000_0000);
    send_item(OP_INSERT, 32'h0000_0000, 32'hFFFF_FFFF);
    send_item(OP_INSERT, 32'hFFFF_FFFF, 32'h0000_0001);
    send_item(OP_INSERT, 32'h0000_01FF, 32'h0000_0002);
    send_item(OP_LOOKUP, 32'h0000_01FF, 32'h0000_0000);
    send_item(OP_INSERT, 32'hFFFF_FFFF, 32'h0000_0001);
    send_item(OP_INSERT, 32'hFFFF_FFFF, 32'h8000_0000);
    send_item(OP_INSERT, 32'hFFFF_FFFF, 32'h0000_0000);
    send_item(OP_LOOKUP, 32'hFFFF_FFFF, 32'hDEAD_BEEF);
    send_item(OP_LOOKUP, 32'h0000_02FF, 32'hFFFF_FFFF);
    send_item(OP_LOOKUP, 32'h0000_0100, 32'h0000_0000);
    send_item(OP_INSERT, 32'h1234_5680, 32'h5555_5555);
    send_item(OP_INSERT, 32'h1234_5680, 32'hAAAA_AAAA);
    send_item(OP_LOOKUP, 32'h1234_5680, 32'h0000_0000);
    send_item(OP_LOOKUP, 32'h0000_0000, 32'h0000_0000);
    wait_drained();
  endtask

  task automatic test_random(int count);
    int               pick;
    int               i;
    op_t              op;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] val;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (stored_keys.size() == 0 && pick >= 12 && pick < 72) pick = 0;
      i = (stored_keys.size() == 0) ? 0 : $urandom_range(0, stored_keys.size() - 1);
      if (pick < 12) begin
        op = OP_INSERT; key = random_key(); val = nonzero_value();
      end else if (pick < 30) begin
        op = OP_INSERT; key = stored_keys[i]; val = stored_vals[i];
      end else if (pick < 42) begin
        op = OP_INSERT; key = stored_keys[i]; val = nonzero_value();
      end else if (pick < 72) begin
        op = OP_LOOKUP; key = stored_keys[i]; val = $urandom;
      end else if (pick < 87) begin
        op = OP_LOOKUP; key = random_key(); val = $urandom;
      end else if (pick < 92) begin
        op = OP_INSERT; key = random_key(); val = '0;
      end else begin
        op  = op_t'($urandom_range(0, 1));
        key = $urandom;
        val = ($urandom_range(0, 3) == 0) ? '0 : VAL_W'($urandom);
      end
      send_item(op, key, val);
    end
    wait_drained();
  endtask

  task automatic test_backpressure();
    steady_send = 1'b1;
    hold_req = 1'b1;
    for (int n = 0; n < 16; n++) begin
      if (n % 2 == 0 || stored_keys.size() == 0)
        send_item(OP_LOOKUP, random_key(), $urandom);
      else
        send_item(OP_LOOKUP, stored_keys[$urandom_range(0, stored_keys.size() - 1)], '0);
    end
    steady_send = 1'b0;
    wait_drained();
  endtask

  task automatic test_fill_table();
    int i;
    while (tbl_count < TABLE_SIZE - 1) send_item(OP_INSERT, random_key(), nonzero_value());
    i = $urandom_range(0, stored_keys.size() - 1);
    send_item(OP_INSERT, random_key(), nonzero_value());
    send_item(OP_INSERT, stored_keys[i], stored_vals[i]);
    send_item(OP_INSERT, random_key(), 32'h0000_0000);
    send_item(OP_LOOKUP, stored_keys[i], 32'h0000_0000);
    send_item(OP_LOOKUP, random_key(), 32'hFFFF_FFFF);
    wait_drained();
  endtask

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = '0;
    out_tready = 1'b0;
    tbl_count  = 0;
    for (int n = 0; n < TABLE_SIZE; n++) begin
      tbl_used[n] = 1'b0;
      tbl_key[n]  = '0;
      tbl_val[n]  = '0;
    end
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed();
    test_random(1050);
    test_backpressure();
    test_fill_table();
    test_random(300);

    repeat (TABLE_SIZE + 20) @(posedge clk);
    $display("Sent %0d items, checked %0d results; table ended with %0d of %0d slots used.",
             items_sent, replies_seen, tbl_count, TABLE_SIZE);
    $display("Statuses: inserted %0d, present %0d, collision %0d, full %0d, found %0d, miss %0d, zero %0d.",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3],
             status_seen[4], status_seen[5], status_seen[6]);
    if (err_count == 0 && pending_replies.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+src
src/lpht_pkg.sv
src/lpht_ctrl.sv
src/lpht_dp.sv
src/linear_probe_hash_table.sv
src/lpht_chk.sv
tb/tb_top.sv
